/* rtl/sbt_pkg.sv */
// Package for the source byte tokenizer: token kinds, queue sizes, result record and bundle.
// No dependencies.
package sbt_pkg;

    localparam int POS_BITS = 32;
    localparam int KIND_W   = 6;
    localparam int OUT_POS_W = 32;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    typedef logic [POS_BITS-1:0] t_pos;
    typedef logic [KIND_W-1:0]   t_kind;

    localparam t_kind K_IDENT  = 6'd0;
    localparam t_kind K_NUM    = 6'd1;
    localparam t_kind K_FLOAT  = 6'd2;
    localparam t_kind K_STRING = 6'd3;
    localparam t_kind K_UNKNOWN = 6'd4;
    localparam t_kind K_NE     = 6'd5;
    localparam t_kind K_BANG   = 6'd6;
    localparam t_kind K_LE     = 6'd7;
    localparam t_kind K_LT     = 6'd8;
    localparam t_kind K_GE     = 6'd9;
    localparam t_kind K_GT     = 6'd10;
    localparam t_kind K_PLUSEQ = 6'd11;
    localparam t_kind K_PLUS   = 6'd12;
    localparam t_kind K_MINUSEQ = 6'd13;
    localparam t_kind K_MINUS  = 6'd14;
    localparam t_kind K_SLASH  = 6'd15;
    localparam t_kind K_POW    = 6'd16;
    localparam t_kind K_STAREQ = 6'd17;
    localparam t_kind K_STAR   = 6'd18;
    localparam t_kind K_ASSIGN = 6'd19;
    localparam t_kind K_ANDAND = 6'd20;
    localparam t_kind K_AMP    = 6'd21;
    localparam t_kind K_OROR   = 6'd22;
    localparam t_kind K_ELLIP  = 6'd23;
    localparam t_kind K_DOT    = 6'd24;
    localparam t_kind K_LPAREN = 6'd25;
    localparam t_kind K_RPAREN = 6'd26;
    localparam t_kind K_LBRACE = 6'd27;
    localparam t_kind K_RBRACE = 6'd28;
    localparam t_kind K_LBRACK = 6'd29;
    localparam t_kind K_RBRACK = 6'd30;
    localparam t_kind K_COLONEQ = 6'd31;
    localparam t_kind K_COLON  = 6'd32;
    localparam t_kind K_SEMI   = 6'd33;
    localparam t_kind K_COMMA  = 6'd34;
    localparam t_kind K_EOF    = 6'd35;
    localparam t_kind K_STRBYTE = 6'd36;

    // One queued result; end and start already trimmed to the output width.
    typedef struct packed {
        t_kind                 kind;
        logic [OUT_POS_W-1:0]  start_off;
        logic [OUT_POS_W-1:0]  end_off;
        logic [7:0]            value;
        logic                  last;
    } t_result;

    // Up to three results produced by one item.
    typedef struct packed {
        logic [2:0]  valid;
        t_result [2:0] res;
    } t_bundle;

endpackage

/* rtl/sbt_front.sv */
// Front end: lexer state machine that classifies one byte per cycle into a bundle, when space allows.
// Depends on sbt_pkg.
module sbt_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [7:0]      i_source_byte,
    input  logic            i_has_byte,
    input  logic            i_end_of_source,
    output logic            o_push,
    output sbt_pkg::t_bundle o_bundle,
    input  logic            i_space_ok
);
    import sbt_pkg::*;

    typedef enum logic [4:0] {
        M_IDLE, M_NUM, M_FLT, M_IDENT, M_STR, M_ESC, M_BANG, M_LT, M_GT,
        M_PLUS, M_MINUS, M_STAR, M_AMP, M_PIPE, M_DOT, M_DOT2, M_COLON
    } t_mode;

    t_mode r_mode, n_mode;
    t_pos  r_start, n_start;
    t_pos  r_off, n_off;

    t_result  rs [3];
    logic [1:0] cnt;
    logic [2:0] vbits;

    assign o_ready = i_space_ok;
    wire take = i_valid && i_space_ok;

    function automatic t_result mk(t_kind k, t_pos s, t_pos e, logic [7:0] v);
        t_result r;
        r.kind = k;
        r.start_off = OUT_POS_W'(s);
        r.end_off = OUT_POS_W'(e);
        r.value = v;
        r.last = 1'b0;
        return r;
    endfunction

    function automatic logic is_dig(logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction
    function automatic logic is_ids(logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_" || b[7];
    endfunction

    always_comb begin
        t_pos off, e, sp;
        t_mode mode;
        logic [7:0] b;
        logic reidle, emit_one, emit_two;
        t_kind one, two, fk;
        logic fe;
        off = r_off;
        e = r_off + t_pos'(1);
        sp = r_start;
        mode = r_mode;
        b = i_source_byte;
        reidle = 1'b0;
        emit_one = 1'b0;
        emit_two = 1'b0;
        one = K_IDENT;
        two = K_IDENT;
        fk = K_IDENT;
        fe = 1'b0;
        cnt = 2'd0;
        for (int i = 0; i < 3; i++) rs[i] = mk(K_IDENT, '0, '0, 8'd0);
        n_off = r_off;
        if (i_has_byte) begin
            n_off = e;
            unique case (mode)
                M_IDLE: reidle = 1'b1;
                M_NUM, M_FLT: begin
                    if (is_dig(b)) begin
                    end else if (b == "." && mode == M_NUM) begin
                        mode = M_FLT;
                    end else begin
                        rs[cnt] = mk(mode == M_FLT ? K_FLOAT : K_NUM, sp, off, 8'd0);
                        cnt = cnt + 2'd1;
                        reidle = 1'b1;
                    end
                end
                M_IDENT: begin
                    if (!(is_ids(b) || is_dig(b))) begin
                        rs[cnt] = mk(K_IDENT, sp, off, 8'd0);
                        cnt = cnt + 2'd1;
                        reidle = 1'b1;
                    end
                end
                M_STR: begin
                    if (b == "\"") begin
                        rs[cnt] = mk(K_STRING, sp, e, 8'd0);
                        cnt = cnt + 2'd1;
                        mode = M_IDLE;
                    end else if (b == "\\") begin
                        mode = M_ESC;
                    end else begin
                        rs[cnt] = mk(K_STRBYTE, off, e, b);
                        cnt = cnt + 2'd1;
                    end
                end
                M_ESC: begin
                    rs[cnt] = mk(K_STRBYTE, off - t_pos'(1), e,
                                 b == "n" ? 8'd10 : (b == "t" ? 8'd9 : b));
                    cnt = cnt + 2'd1;
                    mode = M_STR;
                end
                M_DOT: begin
                    if (b == ".") mode = M_DOT2;
                    else begin emit_one = 1'b1; one = K_DOT; end
                end
                M_DOT2: if (b == ".") begin emit_two = 1'b1; two = K_ELLIP; end
                M_PIPE: if (b == "|") begin emit_two = 1'b1; two = K_OROR; end
                M_BANG: if (b == "=") begin emit_two = 1'b1; two = K_NE; end
                        else begin emit_one = 1'b1; one = K_BANG; end
                M_LT: if (b == "=") begin emit_two = 1'b1; two = K_LE; end
                      else begin emit_one = 1'b1; one = K_LT; end
                M_GT: if (b == "=") begin emit_two = 1'b1; two = K_GE; end
                      else begin emit_one = 1'b1; one = K_GT; end
                M_PLUS: if (b == "=") begin emit_two = 1'b1; two = K_PLUSEQ; end
                        else begin emit_one = 1'b1; one = K_PLUS; end
                M_MINUS: if (b == "=") begin emit_two = 1'b1; two = K_MINUSEQ; end
                         else begin emit_one = 1'b1; one = K_MINUS; end
                M_STAR: if (b == "*") begin emit_two = 1'b1; two = K_POW; end
                        else if (b == "=") begin emit_two = 1'b1; two = K_STAREQ; end
                        else begin emit_one = 1'b1; one = K_STAR; end
                M_AMP: if (b == "&") begin emit_two = 1'b1; two = K_ANDAND; end
                       else begin emit_one = 1'b1; one = K_AMP; end
                M_COLON: if (b == "=") begin emit_two = 1'b1; two = K_COLONEQ; end
                         else begin emit_one = 1'b1; one = K_COLON; end
                default: reidle = 1'b1;
            endcase
            // Operator prefixes: a completed pair ends here, else fall back to idle lexing.
            // A first dot followed by a second one stays pending as a double dot.
            if (!(r_mode == M_DOT && mode == M_DOT2) && (r_mode == M_DOT
                || r_mode == M_DOT2 || r_mode == M_PIPE
                || r_mode == M_BANG || r_mode == M_LT || r_mode == M_GT || r_mode == M_PLUS
                || r_mode == M_MINUS || r_mode == M_STAR || r_mode == M_AMP
                || r_mode == M_COLON)) begin
                mode = M_IDLE;
                if (emit_two) begin
                    rs[cnt] = mk(two, sp, e, 8'd0);
                    cnt = cnt + 2'd1;
                end else begin
                    if (emit_one) begin
                        rs[cnt] = mk(one, sp, off, 8'd0);
                        cnt = cnt + 2'd1;
                    end
                    reidle = 1'b1;
                end
            end
            if (reidle) begin
                mode = M_IDLE;
                sp = off;
                if (b == " " || (b >= 8'd9 && b <= 8'd13)) begin
                end else if (b == "\"") mode = M_STR;
                else if (is_dig(b)) mode = M_NUM;
                else if (is_ids(b)) mode = M_IDENT;
                else begin
                    unique case (b)
                        "!": mode = M_BANG;
                        "<": mode = M_LT;
                        ">": mode = M_GT;
                        "+": mode = M_PLUS;
                        "-": mode = M_MINUS;
                        "*": mode = M_STAR;
                        "&": mode = M_AMP;
                        "|": mode = M_PIPE;
                        ".": mode = M_DOT;
                        ":": mode = M_COLON;
                        "/": begin rs[cnt] = mk(K_SLASH, off, e, 8'd0); cnt = cnt + 2'd1; end
                        "=": begin rs[cnt] = mk(K_ASSIGN, off, e, 8'd0); cnt = cnt + 2'd1; end
                        "(": begin rs[cnt] = mk(K_LPAREN, off, e, 8'd0); cnt = cnt + 2'd1; end
                        ")": begin rs[cnt] = mk(K_RPAREN, off, e, 8'd0); cnt = cnt + 2'd1; end
                        "{": begin rs[cnt] = mk(K_LBRACE, off, e, 8'd0); cnt = cnt + 2'd1; end
                        "}": begin rs[cnt] = mk(K_RBRACE, off, e, 8'd0); cnt = cnt + 2'd1; end
                        "[": begin rs[cnt] = mk(K_LBRACK, off, e, 8'd0); cnt = cnt + 2'd1; end
                        "]": begin rs[cnt] = mk(K_RBRACK, off, e, 8'd0); cnt = cnt + 2'd1; end
                        ";": begin rs[cnt] = mk(K_SEMI, off, e, 8'd0); cnt = cnt + 2'd1; end
                        ",": begin rs[cnt] = mk(K_COMMA, off, e, 8'd0); cnt = cnt + 2'd1; end
                        default: begin rs[cnt] = mk(K_UNKNOWN, off, e, b); cnt = cnt + 2'd1; end
                    endcase
                end
            end
        end
        n_mode = mode;
        n_start = sp;
        if (i_end_of_source) begin
            fe = 1'b1;
            unique case (mode)
                M_NUM: fk = K_NUM;
                M_FLT: fk = K_FLOAT;
                M_IDENT: fk = K_IDENT;
                M_STR, M_ESC: fk = K_UNKNOWN;
                M_BANG: fk = K_BANG;
                M_LT: fk = K_LT;
                M_GT: fk = K_GT;
                M_PLUS: fk = K_PLUS;
                M_MINUS: fk = K_MINUS;
                M_STAR: fk = K_STAR;
                M_AMP: fk = K_AMP;
                M_DOT: fk = K_DOT;
                M_COLON: fk = K_COLON;
                default: fe = 1'b0;
            endcase
            if (fe) begin
                rs[cnt] = mk(fk, sp, n_off, 8'd0);
                cnt = cnt + 2'd1;
            end
            rs[cnt] = mk(K_EOF, n_off, n_off, 8'd0);
            cnt = cnt + 2'd1;
            n_mode = M_IDLE;
            n_start = '0;
            n_off = '0;
        end
        vbits = (cnt == 2'd0) ? 3'b000 : (cnt == 2'd1) ? 3'b001 :
                (cnt == 2'd2) ? 3'b011 : 3'b111;
        if (cnt != 2'd0) rs[cnt - 2'd1].last = 1'b1;
    end

    always_comb begin
        o_push = take && (vbits != 3'b000);
        o_bundle.valid = vbits;
        for (int i = 0; i < 3; i++) o_bundle.res[i] = rs[i];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_start <= '0;
            r_off <= '0;
        end else if (take) begin
            r_mode <= n_mode;
            r_start <= n_start;
            r_off <= n_off;
        end
    end
endmodule

/* rtl/sbt_back.sv */
// Back end: bundle queue and result serializer feeding the output register.
// Depends on sbt_pkg.
module sbt_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  sbt_pkg::t_bundle i_bundle,
    output logic             o_space_ok,
    output logic             o_valid,
    input  logic             i_ready,
    output sbt_pkg::t_result o_result
);
    import sbt_pkg::*;

    t_bundle r_q [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wp, r_rp;
    logic [QUEUE_AW:0]   r_cnt;
    logic [1:0]          r_sub;
    logic                r_ov;
    t_result             r_out;

    t_bundle head;
    logic    qne, load, pop, last_sub;

    assign head = r_q[r_rp];
    assign qne = r_cnt != '0;
    assign load = qne && (!r_ov || i_ready);
    assign last_sub = (r_sub == 2'd2) || !head.valid[r_sub + 2'd1];
    assign pop = load && last_sub;
    assign o_space_ok = r_cnt < (QUEUE_AW+1)'(QUEUE_DEPTH - 1);
    assign o_valid = r_ov;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (i_push) r_q[r_wp] <= i_bundle;
        if (load) r_out <= head.res[r_sub];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
            r_sub <= '0;
            r_ov <= 1'b0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QUEUE_AW+1)'(i_push) - (QUEUE_AW+1)'(pop);
            if (load) r_sub <= last_sub ? 2'd0 : r_sub + 2'd1;
            if (load) r_ov <= 1'b1;
            else if (i_ready) r_ov <= 1'b0;
        end
    end
endmodule

/* rtl/source_byte_tokenizer_unit.sv */
// Top level of the source byte tokenizer: front lexer, bundle queue, result output.
// Depends on sbt_pkg, sbt_front, sbt_back.
//
//   channel   direction  handshake              payload
//   input     in         i_valid / o_ready      i_source_byte, i_has_byte, i_end_of_source
//   output    out        o_valid / i_ready      o_token_kind, o_start_offset, o_end_offset,
//                                               o_byte_value, o_last_of_run
//
// One input byte per cycle while the queue has room; each byte is decided combinationally.
// The results of an item go out one at a time; an item with up to three results waits in
// the back end until all are out, while the bundle queue keeps the front running.
// Reset is synchronous and clears mode, offsets, queue pointers and output valid.
// A stalled output holds its transaction; the input stalls once three bundles are queued.
module source_byte_tokenizer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_source_byte,
    input  logic        i_has_byte,
    input  logic        i_end_of_source,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [5:0]  o_token_kind,
    output logic [31:0] o_start_offset,
    output logic [31:0] o_end_offset,
    output logic [7:0]  o_byte_value,
    output logic        o_last_of_run
);
    import sbt_pkg::*;

    logic    push, space_ok;
    t_bundle bundle;
    t_result res;

    // Classify the byte and build the results of this transaction.
    sbt_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready,
        .i_source_byte, .i_has_byte, .i_end_of_source,
        .o_push(push), .o_bundle(bundle), .i_space_ok(space_ok)
    );

    // Queue bundles and drain them one result per cycle while the output is ready.
    sbt_back u_back (
        .i_clk, .i_rst_n, .i_push(push), .i_bundle(bundle), .o_space_ok(space_ok),
        .o_valid, .i_ready, .o_result(res)
    );

    assign o_token_kind = res.kind;
    assign o_start_offset = res.start_off;
    assign o_end_offset = res.end_off;
    assign o_byte_value = res.value;
    assign o_last_of_run = res.last;

`ifndef NO_ASSERTIONS
    a_end_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_end_of_source) |-> push)
        else $error("end of source produced no results");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> space_ok)
        else $error("push into full queue");
    a_eof_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_token_kind == K_EOF) |-> o_last_of_run)
        else $error("eof token not last of run");
`endif
endmodule
